// ----- hw/rtl/rgbsw_pkg.sv -----
`default_nettype none

package rgbsw_pkg;

    // Field widths.
    localparam int CFG_W    = 12;
    localparam int PIX_W    = 32;
    localparam int HALF_W   = 16;
    localparam int IDX_W    = 23;
    localparam int CFG_IDX_W = 3;

    // Default store sizing.
    localparam int MAX_PITCH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // One tile gives 32 halfwords: 16 upper halves, then 16 lower halves.
    localparam int TILE_HALVES = 32;
    localparam int TILE_CNT_W  = $clog2(TILE_HALVES);

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PITCH          = 3'd0,
        CFG_PADDED_HEIGHT  = 3'd1,
        CFG_IMAGE_WIDTH    = 3'd2,
        CFG_IMAGE_HEIGHT   = 3'd3,
        CFG_REQUEST_WIDTH  = 3'd4,
        CFG_REQUEST_HEIGHT = 3'd5
    } cfg_idx_t;

    // Register reset values.
    localparam logic [CFG_W-1:0] PITCH_RST  = 12'd4;
    localparam logic [CFG_W-1:0] PHEIGHT_RST = 12'd4;
    localparam logic [CFG_W-1:0] IMAGE_RST  = 12'd1;
    localparam logic [CFG_W-1:0] REQ_RST    = 12'd0;

endpackage

`default_nettype wire

// ----- hw/rtl/rgba8_linear_to_tiled_swizzle_core.sv -----
// RGBA8 linear-to-tiled swizzle core.
// Input channel (in_valid/in_ready, pixel_word) takes 32-bit pixels in raster
// order over the used region. Output channel (out_valid/out_ready) gives one
// 16-bit half word per cycle unless stalled, with its destination halfword index,
// tile_last on the 32nd word of each 4x4 tile and image_last on the image's final word.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata while idle.
// Pixels land in a four-row band memory. The pixel that completes a tile starts
// a readout of 32 words, one memory read per cycle unless the receiver stalls;
// each word passes through the read stage and then the output register.
// Throughput: rows 0 to 2 of a band take one pixel per cycle unless a pixel would
// overwrite the tile being read. In row 3 each tile holds the single read port
// for its whole readout, so that row is slower; when the band width is 4
// the next band also waits for the tile readout, since it reuses those entries.
// A pixel that would complete another tile, or overwrite the tile being read,
// waits until the readout has issued its last read.
// Reset clears the counters, the readout and the output valid flag, and loads
// the register defaults; band memory contents are undefined until written.
// When the receiver stalls, the output word holds and the readout pauses;
// input keeps flowing until one of the conditions above applies.
`default_nettype none

module rgba8_linear_to_tiled_swizzle_core #(
    parameter int MAX_PITCH  = rgbsw_pkg::MAX_PITCH_DEF,
    parameter int MAX_HEIGHT = rgbsw_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_wr_en,
    input  wire logic [rgbsw_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [rgbsw_pkg::CFG_W-1:0]      cfg_wdata,

    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [rgbsw_pkg::PIX_W-1:0]      pixel_word,

    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [rgbsw_pkg::HALF_W-1:0]          half_word,
    output logic [rgbsw_pkg::IDX_W-1:0]           dest_index,
    output logic                                  tile_last,
    output logic                                  image_last
);

    import rgbsw_pkg::*;

    localparam int COL_W = $clog2(MAX_PITCH);
    localparam int AW    = $clog2(4 * MAX_PITCH);
    localparam int DEPTH = 4 * MAX_PITCH;
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_PITCH);
    localparam logic [CFG_W:0] PITCH_LIM  = (CFG_W+1)'(MAX_PITCH);
    localparam logic [CFG_W:0] HEIGHT_LIM = (CFG_W+1)'(MAX_HEIGHT);

    // Configuration registers.
    logic [CFG_W-1:0] pitch_reg, pheight_reg, img_w_reg, img_h_reg, req_w_reg, req_h_reg;

    // Image counters.
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [CFG_W-1:0] row_cnt_reg, row_cnt_next;
    logic [IDX_W-1:0] band_base_reg, band_base_next;

    // Tile readout state.
    logic                  busy_reg, busy_next;
    logic [TILE_CNT_W-1:0] k_reg, k_next;
    logic [COL_W-1:0]      tile_col_reg, tile_col_next;
    logic [IDX_W-1:0]      tile_idx_reg, tile_idx_next;
    logic                  tile_img_reg, tile_img_next;

    // Read stage behind the memory.
    logic                  s1_valid_reg, s1_valid_next;
    logic [TILE_CNT_W-1:0] s1_j_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic                  s1_img_reg;
    logic [PIX_W-1:0]      mem_q_reg;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [HALF_W-1:0]     half_reg;
    logic [IDX_W-1:0]      dest_reg;
    logic                  tlast_reg, ilast_reg;

    // Band memory.
    logic [PIX_W-1:0] band_mem [DEPTH];

    logic [CFG_W:0]   pitch_clip, height_clip;
    logic [CFG_W-1:0] pitch_eff, height_eff;
    logic [CFG_W-1:0] w_sel, h_sel;
    logic [CFG_W:0]   w_rnd, h_rnd;
    logic [CFG_W-1:0] w_used, h_used;
    logic             region_ok;
    logic [1:0]       row_lo;
    logic [COL_W-1:0] col_base;
    logic             tile_pos, trigger, collide;
    logic             in_fire, out_free, issue;
    logic             end_row, end_img;
    logic [AW-1:0]    wr_addr, rd_addr;

    // Used region from the configuration registers.
    always_comb
    begin
        pitch_clip  = ({1'b0, pitch_reg} > PITCH_LIM) ? PITCH_LIM : {1'b0, pitch_reg};
        height_clip = ({1'b0, pheight_reg} > HEIGHT_LIM) ? HEIGHT_LIM : {1'b0, pheight_reg};
        pitch_eff   = pitch_clip[CFG_W-1:0] & ~CFG_W'(3);
        height_eff  = height_clip[CFG_W-1:0] & ~CFG_W'(3);
        w_sel       = (req_w_reg != '0) ? req_w_reg : img_w_reg;
        h_sel       = (req_h_reg != '0) ? req_h_reg : img_h_reg;
        w_rnd       = ({1'b0, w_sel} + (CFG_W+1)'(3)) & ~(CFG_W+1)'(3);
        h_rnd       = ({1'b0, h_sel} + (CFG_W+1)'(3)) & ~(CFG_W+1)'(3);
        w_used      = (w_rnd > {1'b0, pitch_eff}) ? pitch_eff : w_rnd[CFG_W-1:0];
        h_used      = (h_rnd > {1'b0, height_eff}) ? height_eff : h_rnd[CFG_W-1:0];
        region_ok   = (w_used != '0) && (h_used != '0);
    end

    // Position of the next pixel and the input interlock.
    always_comb
    begin
        row_lo   = row_cnt_reg[1:0];
        col_base = col_cnt_reg & ~COL_W'(3);
        tile_pos = (row_lo == 2'd3) && (col_cnt_reg[1:0] == 2'd3);
        trigger  = region_ok && tile_pos;
        collide  = (col_base == tile_col_reg);
        in_ready = !(busy_reg && (tile_pos || collide));
        in_fire  = in_valid && in_ready;
        end_row  = ((CFG_W+1)'(col_cnt_reg) + (CFG_W+1)'(1)) >= {1'b0, w_used};
        end_img  = end_row && (({1'b0, row_cnt_reg} + (CFG_W+1)'(1)) >= {1'b0, h_used});
        wr_addr  = AW'(AW'(row_lo) * ROW_STRIDE) + AW'(col_cnt_reg);
        rd_addr  = AW'(AW'(k_reg[3:2]) * ROW_STRIDE) + AW'(tile_col_reg | COL_W'(k_reg[1:0]));
    end

    // Readout flow: issue a read when the read stage can move on.
    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        issue          = busy_reg && (!s1_valid_reg || out_free);
        out_valid_next = s1_valid_reg ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
        s1_valid_next  = issue ? 1'b1 : (out_free ? 1'b0 : s1_valid_reg);
    end

    // Counter and tile start next state.
    always_comb
    begin
        col_cnt_next   = col_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        band_base_next = band_base_reg;
        busy_next      = busy_reg;
        k_next         = k_reg;
        tile_col_next  = tile_col_reg;
        tile_idx_next  = tile_idx_reg;
        tile_img_next  = tile_img_reg;

        if (issue)
        begin
            k_next = k_reg + TILE_CNT_W'(1);
            if (k_reg == TILE_CNT_W'(TILE_HALVES - 1))
            begin
                busy_next = 1'b0;
            end
        end

        if (in_fire && region_ok)
        begin
            if (trigger)
            begin
                busy_next     = 1'b1;
                k_next        = '0;
                tile_col_next = col_base;
                tile_idx_next = band_base_reg + IDX_W'({col_base, 3'b000});
                tile_img_next = end_img;
            end
            if (end_img)
            begin
                col_cnt_next   = '0;
                row_cnt_next   = '0;
                band_base_next = '0;
            end
            else if (end_row)
            begin
                col_cnt_next = '0;
                row_cnt_next = row_cnt_reg + CFG_W'(1);
                if (row_lo == 2'd3)
                begin
                    band_base_next = band_base_reg + IDX_W'({pitch_eff, 3'b000});
                end
            end
            else
            begin
                col_cnt_next = col_cnt_reg + COL_W'(1);
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg   <= PITCH_RST;
            pheight_reg <= PHEIGHT_RST;
            img_w_reg   <= IMAGE_RST;
            img_h_reg   <= IMAGE_RST;
            req_w_reg   <= REQ_RST;
            req_h_reg   <= REQ_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_PITCH:          pitch_reg   <= cfg_wdata;
                CFG_PADDED_HEIGHT:  pheight_reg <= cfg_wdata;
                CFG_IMAGE_WIDTH:    img_w_reg   <= cfg_wdata;
                CFG_IMAGE_HEIGHT:   img_h_reg   <= cfg_wdata;
                CFG_REQUEST_WIDTH:  req_w_reg   <= cfg_wdata;
                CFG_REQUEST_HEIGHT: req_h_reg   <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            band_base_reg <= '0;
            busy_reg      <= 1'b0;
            k_reg         <= '0;
            tile_col_reg  <= '0;
            tile_idx_reg  <= '0;
            tile_img_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            band_base_reg <= band_base_next;
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            tile_col_reg  <= tile_col_next;
            tile_idx_reg  <= tile_idx_next;
            tile_img_reg  <= tile_img_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Band memory: pixel write port and readout port.
    always_ff @(posedge clk)
    begin
        if (in_fire && region_ok)
        begin
            band_mem[wr_addr] <= pixel_word;
        end
        if (issue)
        begin
            mem_q_reg <= band_mem[rd_addr];
        end
    end

    // Read stage and output word payload.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_j_reg   <= k_reg;
            s1_idx_reg <= tile_idx_reg;
            s1_img_reg <= tile_img_reg;
        end
        if (s1_valid_reg && out_free)
        begin
            half_reg  <= s1_j_reg[TILE_CNT_W-1] ? mem_q_reg[HALF_W-1:0]
                                                : mem_q_reg[PIX_W-1:HALF_W];
            dest_reg  <= s1_idx_reg + IDX_W'(s1_j_reg);
            tlast_reg <= (s1_j_reg == TILE_CNT_W'(TILE_HALVES - 1));
            ilast_reg <= (s1_j_reg == TILE_CNT_W'(TILE_HALVES - 1)) && s1_img_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign half_word  = half_reg;
    assign dest_index = dest_reg;
    assign tile_last  = tlast_reg;
    assign image_last = ilast_reg;

`ifndef SYNTH
    // A tile's last word lands on the last slot of a 32-word aligned block.
    a_tile_last_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tile_last) |-> (dest_index[4:0] == 5'h1f))
        else $error("tile_last word not at end of aligned tile block");

    // The image ends only on the last word of a tile.
    a_image_last_tile: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && image_last) |-> tile_last)
        else $error("image_last without tile_last");

    // No pixel write may hit the tile columns still being read out.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && busy_reg) |-> (col_base != tile_col_reg))
        else $error("pixel write into tile under readout");

    // A readout ends only after its 32nd read was issued.
    a_readout_len: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> ($past(issue) && ($past(k_reg) == TILE_CNT_W'(TILE_HALVES - 1))))
        else $error("tile readout ended early");
`endif

endmodule

`default_nettype wire
